[rtl/core/mexp_pkg.sv]
// Shared types, constants and microcode ROM for the modular exponentiation block.
package mexp_pkg;

  // operand width of modulus, exponents and value
  localparam int unsigned OpW     = 32;
  // port width of register data, value and result
  localparam int unsigned DataW   = 32;
  localparam int unsigned CntW    = $clog2(OpW);
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned PcW     = 4;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] RegModulus = 2'd0;
  localparam logic [RegIdxW-1:0] RegEncExp  = 2'd1;
  localparam logic [RegIdxW-1:0] RegDecExp  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_EXP_ZERO,
    JMP_MOD_ZERO,
    JMP_BIT_CLEAR,
    JMP_CNT_NZ
  } jump_e;

  typedef enum logic {
    A_ONE,
    A_BASE
  } asel_e;

  typedef enum logic [1:0] {
    B_VALUE,
    B_BASE,
    B_ACC
  } bsel_e;

  typedef enum logic {
    DST_BASE,
    DST_ACC
  } dst_e;

  typedef enum logic [1:0] {
    RES_ACC,
    RES_ONE,
    RES_ZERO
  } res_e;

  // one control word of the sequencer
  typedef struct packed {
    logic           mul;     // run a modular multiply, hold until it ends
    asel_e          a_sel;   // addend operand (must be below modulus, or one)
    bsel_e          b_sel;   // operand scanned MSB first
    dst_e           dst;     // where the product goes
    logic           shift;   // advance exponent bit at end of step
    jump_e          jump;
    logic [PcW-1:0] target;
    logic           fin;     // hand result to output register
    res_e           res;
  } ucode_t;

  // program addresses
  localparam logic [PcW-1:0] PcExpChk  = 4'd0;
  localparam logic [PcW-1:0] PcModChk  = 4'd1;
  localparam logic [PcW-1:0] PcReduce  = 4'd2;
  localparam logic [PcW-1:0] PcBitChk  = 4'd3;
  localparam logic [PcW-1:0] PcMulAcc  = 4'd4;
  localparam logic [PcW-1:0] PcSquare  = 4'd5;
  localparam logic [PcW-1:0] PcLoop    = 4'd6;
  localparam logic [PcW-1:0] PcFinAcc  = 4'd7;
  localparam logic [PcW-1:0] PcFinOne  = 4'd8;
  localparam logic [PcW-1:0] PcFinZero = 4'd9;

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    w.mul    = 1'b0;
    w.a_sel  = A_ONE;
    w.b_sel  = B_VALUE;
    w.dst    = DST_BASE;
    w.shift  = 1'b0;
    w.jump   = JMP_NEVER;
    w.target = PcExpChk;
    w.fin    = 1'b0;
    w.res    = RES_ACC;
    case (pc)
      PcExpChk: begin
        w.jump   = JMP_EXP_ZERO;
        w.target = PcFinOne;
      end
      PcModChk: begin
        w.jump   = JMP_MOD_ZERO;
        w.target = PcFinZero;
      end
      PcReduce: begin
        // base = 1 * value mod n
        w.mul   = 1'b1;
        w.a_sel = A_ONE;
        w.b_sel = B_VALUE;
        w.dst   = DST_BASE;
      end
      PcBitChk: begin
        w.jump   = JMP_BIT_CLEAR;
        w.target = PcSquare;
      end
      PcMulAcc: begin
        w.mul   = 1'b1;
        w.a_sel = A_BASE;
        w.b_sel = B_ACC;
        w.dst   = DST_ACC;
      end
      PcSquare: begin
        w.mul   = 1'b1;
        w.a_sel = A_BASE;
        w.b_sel = B_BASE;
        w.dst   = DST_BASE;
        w.shift = 1'b1;
      end
      PcLoop: begin
        w.jump   = JMP_CNT_NZ;
        w.target = PcBitChk;
      end
      PcFinAcc: begin
        w.fin = 1'b1;
        w.res = RES_ACC;
      end
      PcFinOne: begin
        w.fin = 1'b1;
        w.res = RES_ONE;
      end
      PcFinZero: begin
        w.fin = 1'b1;
        w.res = RES_ZERO;
      end
      default: begin
        w.fin = 1'b1;
        w.res = RES_ZERO;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/modular_exponentiation.sv]
// Microcoded modular exponentiation (right-to-left square and multiply).
//
// Usage:
//  - Configuration: write modulus (index 0), encryption exponent (1) and
//    decryption exponent (2) through cfg_we_i/cfg_index_i/cfg_data_i while
//    the block is idle. Index 3 is ignored. Reset values: modulus 1,
//    exponents 0.
//  - Input channel: in_valid_i/in_stall_o carry mode_i and value_i. One item
//    is in flight at a time; in_stall_o is high from the transfer until the
//    result is loaded into the output register.
//  - Output channel: out_valid_o/out_stall_i carry result_o. The output
//    register holds a finished result while the receiver stalls, and a new
//    item may be taken meanwhile; the next result waits in the sequencer.
//  - Cost: every modular multiply runs in one shared bit-serial unit
//    (interleaved add and reduce, one multiplier bit per cycle). Base
//    reduction costs one multiply, then each of the 32 exponent bits costs
//    a square plus a multiply when the bit is set, plus two sequencer
//    steps. Exponent zero or modulus zero finish without any multiply.
//  - Reset (rst_ni low, asynchronous) returns to idle with no result pending.
module modular_exponentiation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mexp_pkg::RegIdxW-1:0]     cfg_index_i,
  input  logic [mexp_pkg::DataW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [mexp_pkg::DataW-1:0]       value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mexp_pkg::DataW-1:0]       result_o
);

  localparam int unsigned W  = mexp_pkg::OpW;
  localparam int unsigned CW = mexp_pkg::CntW;

  // configuration registers
  logic [W-1:0] mod_q, enc_exp_q, dec_exp_q;

  // sequencer
  mexp_pkg::state_e state_q, state_d;
  logic [mexp_pkg::PcW-1:0] pc_q, pc_d;
  mexp_pkg::ucode_t uw;
  logic jump_take, step_adv, fin_load, in_xfer, out_xfer;

  // datapath
  logic [W-1:0]  value_q, base_q, acc_q, exp_q;
  logic [CW-1:0] bit_cnt_q;

  // bit-serial modular multiplier
  logic          mul_busy_q;
  logic [CW-1:0] mcnt_q;
  logic [W-1:0]  ma_q, mb_q, mr_q;
  logic          mul_start, mul_last;
  logic [W+1:0]  m_sum, m_n1, m_n2;
  logic [W-1:0]  mr_next;

  // output register
  logic              out_valid_q;
  logic [W-1:0]      res_q;
  logic [W-1:0]      res_sel;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q     <= W'(1);
      enc_exp_q <= '0;
      dec_exp_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mexp_pkg::RegModulus: mod_q     <= cfg_data_i[W-1:0];
        mexp_pkg::RegEncExp:  enc_exp_q <= cfg_data_i[W-1:0];
        mexp_pkg::RegDecExp:  dec_exp_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // current control word and branch decision
  always_comb begin
    uw = mexp_pkg::ucode_rom(pc_q);
    case (uw.jump)
      mexp_pkg::JMP_NEVER:     jump_take = 1'b0;
      mexp_pkg::JMP_EXP_ZERO:  jump_take = (exp_q == '0);
      mexp_pkg::JMP_MOD_ZERO:  jump_take = (mod_q == '0);
      mexp_pkg::JMP_BIT_CLEAR: jump_take = !exp_q[0];
      mexp_pkg::JMP_CNT_NZ:    jump_take = (bit_cnt_q != '0);
      default:                 jump_take = 1'b0;
    endcase
  end

  // step sequencing: multiply steps hold until the unit finishes,
  // finish steps hold until the output register is free or draining
  always_comb begin
    step_adv  = 1'b0;
    fin_load  = 1'b0;
    mul_start = 1'b0;
    if (state_q == mexp_pkg::ST_RUN) begin
      if (uw.fin) begin
        fin_load = !out_valid_q || !out_stall_i;
      end else if (uw.mul) begin
        mul_start = !mul_busy_q;
        step_adv  = mul_busy_q && mul_last;
      end else begin
        step_adv = 1'b1;
      end
    end
    pc_d = pc_q;
    if (in_xfer) begin
      pc_d = mexp_pkg::PcExpChk;
    end else if (step_adv) begin
      pc_d = jump_take ? uw.target : pc_q + mexp_pkg::PcW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mexp_pkg::ST_IDLE: if (in_xfer) state_d = mexp_pkg::ST_RUN;
      mexp_pkg::ST_RUN:  if (fin_load) state_d = mexp_pkg::ST_IDLE;
      default:           state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    case (state_q)
      mexp_pkg::ST_IDLE: in_stall_o = 1'b0;
      mexp_pkg::ST_RUN:  in_stall_o = 1'b1;
      default:           in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::ST_IDLE;
      pc_q    <= mexp_pkg::PcExpChk;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // multiplier step: r = 2r + (b msb ? a : 0), then bring below n.
  // a < n (or a = 1 <= n) and r < n keep the sum below 3n.
  assign mul_last = (mcnt_q == CW'(W - 1));
  assign m_n1     = {2'b00, mod_q};
  assign m_n2     = {1'b0, mod_q, 1'b0};
  assign m_sum    = {1'b0, mr_q, 1'b0} + (mb_q[W-1] ? {2'b00, ma_q} : '0);

  always_comb begin
    if (m_sum >= m_n2) begin
      mr_next = W'(m_sum - m_n2);
    end else if (m_sum >= m_n1) begin
      mr_next = W'(m_sum - m_n1);
    end else begin
      mr_next = m_sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mcnt_q     <= '0;
    end else if (mul_start) begin
      mul_busy_q <= 1'b1;
      mcnt_q     <= '0;
    end else if (mul_busy_q) begin
      mul_busy_q <= !mul_last;
      mcnt_q     <= mcnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      ma_q <= (uw.a_sel == mexp_pkg::A_BASE) ? base_q : W'(1);
      case (uw.b_sel)
        mexp_pkg::B_VALUE: mb_q <= value_q;
        mexp_pkg::B_BASE:  mb_q <= base_q;
        mexp_pkg::B_ACC:   mb_q <= acc_q;
        default:           mb_q <= '0;
      endcase
      mr_q <= '0;
    end else if (mul_busy_q) begin
      mb_q <= {mb_q[W-2:0], 1'b0};
      mr_q <= mr_next;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      value_q   <= value_i[W-1:0];
      exp_q     <= mode_i ? dec_exp_q : enc_exp_q;
      acc_q     <= W'(1);
      bit_cnt_q <= '0;
    end else if (step_adv) begin
      if (uw.mul) begin
        if (uw.dst == mexp_pkg::DST_ACC) acc_q <= mr_next;
        else base_q <= mr_next;
      end
      if (uw.shift) begin
        exp_q     <= exp_q >> 1;
        bit_cnt_q <= bit_cnt_q + CW'(1);
      end
    end
  end

  // output register
  always_comb begin
    case (uw.res)
      mexp_pkg::RES_ACC:  res_sel = acc_q;
      mexp_pkg::RES_ONE:  res_sel = W'(1);
      mexp_pkg::RES_ZERO: res_sel = '0;
      default:            res_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) res_q <= res_sel;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = mexp_pkg::DataW'(res_q);

  // the multiplier only runs for an item in flight
  a_mul_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_busy_q |-> state_q == mexp_pkg::ST_RUN)
    else $error("multiplier busy while idle");

  // partial remainder stays reduced
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_busy_q && mod_q != '0) |-> mr_q < mod_q)
    else $error("partial remainder not below modulus");

  // base is reduced once the loop has started
  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::ST_RUN && mod_q != '0 &&
     (pc_q == mexp_pkg::PcBitChk || pc_q == mexp_pkg::PcMulAcc ||
      pc_q == mexp_pkg::PcSquare || pc_q == mexp_pkg::PcLoop))
    |-> base_q < mod_q)
    else $error("base not reduced");

  // sequencer never leaves the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mexp_pkg::ST_RUN |-> pc_q <= mexp_pkg::PcFinZero)
    else $error("program counter out of range");

  // a result is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

endmodule
